[rtl/core/line_fragment_reassembly_defines.svh]
`ifndef LINE_FRAGMENT_REASSEMBLY_DEFINES_SVH
`define LINE_FRAGMENT_REASSEMBLY_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define LFR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LFR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/lfr_pkg.sv]
`default_nettype none
package lfr_pkg;

	localparam int unsigned LINE_PIXELS_DEF = 4096;
	localparam int unsigned MAX_FRAGMENTS   = 64;
	localparam int unsigned GAMMA_MILLI     = 1000;

	localparam int unsigned ADDR_W = 20;   // fid * fsize + offset

	typedef enum logic [1:0] {
		OP_PIXEL = 2'd0,
		OP_READ  = 2'd1,
		OP_ACK   = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		STAT_WRITTEN   = 3'd0,
		STAT_DUPLICATE = 3'd1,
		STAT_COMPLETE  = 3'd2,
		STAT_WRONG     = 3'd3,
		STAT_RANGE     = 3'd4,
		STAT_READ      = 3'd5,
		STAT_ACKED     = 3'd6
	} status_t;

	localparam logic CFG_ENABLE_TRANSFORM = 1'b0;
	localparam logic CFG_HEADER_TYPE      = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WORK,
		ST_COMMIT,
		ST_READ
	} state_t;

	// luminance weights in thousandths
	localparam logic [8:0]  Y_R = 9'd299;
	localparam logic [9:0]  Y_G = 10'd587;
	localparam logic [6:0]  Y_B = 7'd114;
	localparam logic [17:0] Y_TOP = 18'd255500;

	typedef logic [16:0] gamma_lut_t [256];

	function automatic logic [63:0] isqrt64(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] bt;
		logic [63:0] vv;
		r  = '0;
		bt = 64'd1 << 62;
		vv = v;
		for (int i = 0; i < 32; i++)
			if (bt > vv) bt = bt >> 2;
		for (int i = 0; i < 32; i++) begin
			if (bt != 0) begin
				if (vv >= r + bt) begin
					vv = vv - (r + bt);
					r  = (r >> 1) + bt;
				end else begin
					r = r >> 1;
				end
				bt = bt >> 2;
			end
		end
		return r;
	endfunction

	function automatic logic [63:0] log2_q16(logic [31:0] v);
		int unsigned n;
		logic [63:0] m;
		logic [63:0] frac;
		n    = 0;
		frac = '0;
		for (int i = 0; i < 31; i++)
			if ((v >> (n + 1)) != 0) n = n + 1;
		m = 64'(v) << (30 - n);
		for (int k = 1; k <= 16; k++) begin
			m = (m * m) >> 30;
			if (m >= (64'd1 << 31)) begin
				m    = m >> 1;
				frac = frac | (64'd1 << (16 - k));
			end
		end
		return (64'(n) << 16) + frac;
	endfunction

	// (i/255)^(GAMMA_MILLI/1000) in Q16, built at elaboration
	function automatic gamma_lut_t build_gamma_lut();
		gamma_lut_t lut;
		logic [63:0] roots [17];
		logic [63:0] prev;
		logic [63:0] top;
		logic [63:0] neg;
		logic [63:0] e;
		logic [63:0] ip;
		logic [63:0] fp;
		logic [63:0] r;
		logic [63:0] q;
		prev = 64'd1 << 29;
		roots[0] = '0;
		for (int k = 1; k <= 16; k++) begin
			prev = isqrt64(prev << 30);
			roots[k] = prev;
		end
		top = log2_q16(32'd255);
		lut[0] = '0;
		for (int i = 1; i < 256; i++) begin
			neg = top - log2_q16(32'(i));
			e   = (neg * 64'(GAMMA_MILLI) + 64'd500) / 64'd1000;
			ip  = e >> 16;
			fp  = e & 64'hFFFF;
			r   = 64'd1 << 30;
			for (int k = 1; k <= 16; k++)
				if ((fp & (64'd1 << (16 - k))) != 0)
					r = (r * roots[k] + (64'd1 << 29)) >> 30;
			r = (ip >= 31) ? 64'd0 : (r >> ip);
			q = (r + 64'd8192) >> 14;
			lut[i] = (q > 64'd65536) ? 17'd65536 : q[16:0];
		end
		return lut;
	endfunction

	localparam gamma_lut_t GAMMA_LUT = build_gamma_lut();

endpackage
`default_nettype wire

[rtl/core/lfr_ifs.sv]
`default_nettype none
interface lfr_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [7:0]  packet_type;
	logic [31:0] line_id;
	logic [5:0]  frag_index;
	logic [6:0]  frag_total;
	logic [12:0] frag_pixels;
	logic [11:0] pixel_offset;
	logic [7:0]  red_in;
	logic [7:0]  green_in;
	logic [7:0]  blue_in;
	logic        end_of_fragment;

	modport source (output valid, opcode, packet_type, line_id, frag_index, frag_total,
		frag_pixels, pixel_offset, red_in, green_in, blue_in, end_of_fragment,
		input ready);
	modport sink (input valid, opcode, packet_type, line_id, frag_index, frag_total,
		frag_pixels, pixel_offset, red_in, green_in, blue_in, end_of_fragment,
		output ready);
endinterface

interface lfr_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [7:0]  red_out;
	logic [7:0]  green_out;
	logic [7:0]  blue_out;
	logic        line_ready;
	logic [31:0] ready_line_number;

	modport source (output valid, status, red_out, green_out, blue_out, line_ready,
		ready_line_number, input ready);
	modport sink (input valid, status, red_out, green_out, blue_out, line_ready,
		ready_line_number, output ready);
endinterface

interface lfr_cfg_if;
	logic       valid;
	logic       ready;
	logic       index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/core/lfr_xform.sv]
`default_nettype none
module lfr_xform
	import lfr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [7:0] red,
	input  wire logic [7:0] green,
	input  wire logic [7:0] blue,
	output logic            done,
	output logic [7:0]      red_x,
	output logic [7:0]      green_x,
	output logic [7:0]      blue_x
);
	// x / 1000 as (x * M) >> 28, exact for x up to Y_TOP
	localparam logic [18:0] RECIP_M  = 19'd268436;
	localparam int unsigned RECIP_SH = 28;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [17:0] y_s1;
	logic [7:0]  r_s1, g_s1, b_s1, r_s2, g_s2, b_s2, r_s3, g_s3, b_s3;
	logic [7:0]  idx_s2;
	logic [16:0] f_s3;
	logic [7:0]  r_s4, g_s4, b_s4;
	logic [36:0] quot_full;
	logic [24:0] pr, pg, pb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign quot_full = 37'(Y_TOP - y_s1) * 37'(RECIP_M);
	assign pr = 25'(r_s3) * 25'(f_s3) + 25'd32768;
	assign pg = 25'(g_s3) * 25'(f_s3) + 25'd32768;
	assign pb = 25'(b_s3) * 25'(f_s3) + 25'd32768;

	always_ff @(posedge clk) begin
		if (start) begin
			y_s1 <= 18'(Y_R * 18'(red)) + 18'(Y_G * 18'(green)) + 18'(Y_B * 18'(blue));
			r_s1 <= red;
			g_s1 <= green;
			b_s1 <= blue;
		end
		if (v_s1) begin
			idx_s2 <= quot_full[RECIP_SH +: 8];
			r_s2   <= r_s1;
			g_s2   <= g_s1;
			b_s2   <= b_s1;
		end
		if (v_s2) begin
			f_s3 <= GAMMA_LUT[idx_s2];
			r_s3 <= r_s2;
			g_s3 <= g_s2;
			b_s3 <= b_s2;
		end
		if (v_s3) begin
			r_s4 <= pr[23:16];
			g_s4 <= pg[23:16];
			b_s4 <= pb[23:16];
		end
	end

	assign done    = v_s4;
	assign red_x   = r_s4;
	assign green_x = g_s4;
	assign blue_x  = b_s4;
endmodule
`default_nettype wire

[rtl/core/lfr_store.sv]
`default_nettype none
module lfr_store
	import lfr_pkg::*;
#(
	parameter int unsigned DEPTH = 2 * LINE_PIXELS_DEF,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [23:0]   wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic [23:0]        rdata
);
	logic [23:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re) rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[rtl/core/line_fragment_reassembly.sv]
// line fragment reassembly into a double-buffered line store
// channels: item (sink) carries one fragment pixel, a read or an acknowledge;
// result (source) returns exactly one result per item; cfg (sink, always
// ready) writes enable_transform (index 0) and image_header_type (index 1).
// one item is in work at a time: every item, whatever its opcode, passes through
// the four-stage gamma transform before its result is formed, and a read takes an
// extra read state for the registered memory read; the next item is taken the
// cycle after the result is formed.
// the result sits in an output register: the block takes the next item while
// it waits, and stalls only before forming the next result if the receiver
// still holds the previous one.
// reset clears the line state, seen bitmap, count, bank select and ready
// flag; the pixel memory is not cleared and a pixel never written is
// undefined when read.
`default_nettype none
`include "line_fragment_reassembly_defines.svh"
module line_fragment_reassembly
	import lfr_pkg::*;
#(
	parameter int unsigned LINE_PIXELS = LINE_PIXELS_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	lfr_item_if.sink     item,
	lfr_result_if.source result,
	lfr_cfg_if.sink      cfg
);
	localparam int unsigned MEM_AW = $clog2(2 * LINE_PIXELS);

	state_t state_q, state_nxt;

	// configuration
	logic       xform_en_q;
	logic [7:0] hdr_type_q;

	// item under work
	logic [1:0]  opcode_q;
	logic [7:0]  ptype_q;
	logic [31:0] lid_q;
	logic [5:0]  fid_q;
	logic [6:0]  total_q;
	logic [12:0] fsize_q;
	logic [11:0] offset_q;
	logic [7:0]  r_q, g_q, b_q;
	logic        eof_q;
	logic [ADDR_W-1:0] addr_q;

	// line state
	logic [31:0]              cur_line_q;
	logic [MAX_FRAGMENTS-1:0] seen_q;
	logic [6:0]               cnt_q;
	logic                     fill_bank_q;
	logic                     ready_flag_q;
	logic [31:0]              ready_line_q;

	// output register
	logic        ovalid_q;
	logic [2:0]  ostatus_q;
	logic [7:0]  ored_q, ogreen_q, oblue_q;
	logic        oready_flag_q;
	logic [31:0] oready_line_q;

	logic accept, out_free, commit;
	logic store_we, store_re;
	logic xf_done;
	logic [7:0] xr, xg, xb;
	logic [23:0] rdata;
	logic [MEM_AW-1:0] waddr, raddr;

	// commit decisions
	logic newline, type_ok, fid_ok, addr_ok, rd_ok, seen_bit, finish_frag, complete;
	logic [MAX_FRAGMENTS-1:0] seen_base, seen_next;
	logic [6:0] cnt_base, cnt_next;
	status_t pix_status;
	logic [7:0] wr_r, wr_g, wr_b;

	assign accept   = item.valid && item.ready;
	assign out_free = !ovalid_q || result.ready;
	assign cfg.ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xform_en_q <= 1'b0;
			hdr_type_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_ENABLE_TRANSFORM: xform_en_q <= cfg.data[0];
				CFG_HEADER_TYPE:      hdr_type_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// capture the item on transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_q <= item.opcode;
			ptype_q  <= item.packet_type;
			lid_q    <= item.line_id;
			fid_q    <= item.frag_index;
			total_q  <= item.frag_total;
			fsize_q  <= item.frag_pixels;
			offset_q <= item.pixel_offset;
			r_q      <= item.red_in;
			g_q      <= item.green_in;
			b_q      <= item.blue_in;
			eof_q    <= item.end_of_fragment;
		end
		// line address, one multiply then add
		if (state_q == ST_WORK)
			addr_q <= ADDR_W'(fid_q) * ADDR_W'(fsize_q) + ADDR_W'(offset_q);
	end

	lfr_xform u_xform (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.red     (item.red_in),
		.green   (item.green_in),
		.blue    (item.blue_in),
		.done    (xf_done),
		.red_x   (xr),
		.green_x (xg),
		.blue_x  (xb)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:   if (accept) state_nxt = ST_WORK;
			ST_WORK:   if (xf_done) state_nxt = ST_COMMIT;
			ST_COMMIT: begin
				if (out_free)
					state_nxt = (opcode_q == OP_READ && rd_ok) ? ST_READ : ST_IDLE;
			end
			ST_READ:   state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// fsm outputs
	always_comb begin
		item.ready = 1'b0;
		commit     = 1'b0;
		case (state_q)
			ST_IDLE:   item.ready = 1'b1;
			ST_COMMIT: commit = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_nxt;
	end

	// pixel decisions against the line state
	always_comb begin
		newline   = lid_q != cur_line_q;
		type_ok   = ptype_q == hdr_type_q;
		fid_ok    = 32'(fid_q) < 32'(MAX_FRAGMENTS);
		addr_ok   = 32'(addr_q) < 32'(LINE_PIXELS);
		rd_ok     = 32'(offset_q) < 32'(LINE_PIXELS);
		seen_base = newline ? '0 : seen_q;
		cnt_base  = newline ? '0 : cnt_q;
		cnt_next  = cnt_base + 7'd1;
		seen_bit  = seen_base[fid_q];
		finish_frag = type_ok && fid_ok && !seen_bit && eof_q;
		seen_next = finish_frag ? (seen_base | (MAX_FRAGMENTS'(1) << fid_q)) : seen_base;
		complete  = finish_frag && (cnt_next == total_q);
		if (!type_ok)      pix_status = STAT_WRONG;
		else if (!fid_ok)  pix_status = STAT_RANGE;
		else if (seen_bit) pix_status = STAT_DUPLICATE;
		else if (complete) pix_status = STAT_COMPLETE;
		else if (addr_ok)  pix_status = STAT_WRITTEN;
		else               pix_status = STAT_RANGE;
		wr_r = xform_en_q ? xr : r_q;
		wr_g = xform_en_q ? xg : g_q;
		wr_b = xform_en_q ? xb : b_q;
	end

	assign store_we = commit && opcode_q == OP_PIXEL && type_ok && fid_ok && !seen_bit
		&& addr_ok;
	assign store_re = commit && opcode_q == OP_READ && rd_ok;
	assign waddr = (fill_bank_q ? MEM_AW'(LINE_PIXELS) : '0) + MEM_AW'(addr_q);
	assign raddr = (fill_bank_q ? '0 : MEM_AW'(LINE_PIXELS)) + MEM_AW'(offset_q);

	lfr_store #(
		.DEPTH (2 * LINE_PIXELS)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (waddr),
		.wdata ({wr_r, wr_g, wr_b}),
		.re    (store_re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// line state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_line_q   <= '0;
			seen_q       <= '0;
			cnt_q        <= '0;
			fill_bank_q  <= 1'b0;
			ready_flag_q <= 1'b0;
			ready_line_q <= '0;
		end else if (commit) begin
			if (opcode_q == OP_PIXEL && type_ok) begin
				cur_line_q <= lid_q;
				seen_q     <= seen_next;
				cnt_q      <= finish_frag ? cnt_next : cnt_base;
				if (complete) begin
					fill_bank_q  <= !fill_bank_q;
					ready_flag_q <= 1'b1;
					ready_line_q <= lid_q;
				end
			end else if (opcode_q == OP_ACK) begin
				ready_flag_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (commit && !store_re) begin
			ovalid_q <= 1'b1;
		end else if (state_q == ST_READ) begin
			ovalid_q <= 1'b1;
		end else if (result.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && !store_re) begin
			ored_q   <= '0;
			ogreen_q <= '0;
			oblue_q  <= '0;
			oready_line_q <= complete && opcode_q == OP_PIXEL ? lid_q : ready_line_q;
			case (opcode_q)
				OP_PIXEL: begin
					ostatus_q     <= pix_status;
					oready_flag_q <= ready_flag_q || complete;
				end
				OP_READ: begin
					ostatus_q     <= STAT_RANGE;
					oready_flag_q <= ready_flag_q;
				end
				OP_ACK: begin
					ostatus_q     <= STAT_ACKED;
					oready_flag_q <= 1'b0;
				end
				default: begin
					ostatus_q     <= STAT_WRONG;
					oready_flag_q <= ready_flag_q;
				end
			endcase
		end else if (state_q == ST_READ) begin
			ostatus_q     <= STAT_READ;
			ored_q        <= rdata[23:16];
			ogreen_q      <= rdata[15:8];
			oblue_q       <= rdata[7:0];
			oready_flag_q <= ready_flag_q;
			oready_line_q <= ready_line_q;
		end
	end

	assign result.valid             = ovalid_q;
	assign result.status            = ostatus_q;
	assign result.red_out           = ored_q;
	assign result.green_out         = ogreen_q;
	assign result.blue_out          = oblue_q;
	assign result.line_ready        = oready_flag_q;
	assign result.ready_line_number = oready_line_q;

	`LFR_ASSERT_NOW(a_count_matches_seen, 1'b1, $countones(seen_q) == 32'(cnt_q), "fragment count disagrees with seen bitmap")
	`LFR_ASSERT_NEXT(a_accept_starts_work, accept, state_q == ST_WORK, "item transfer did not start work")
	`LFR_ASSERT_NEXT(a_read_follows, store_re, state_q == ST_READ, "memory read not followed by read state")
	`LFR_ASSERT_NOW(a_write_at_commit, store_we, state_q == ST_COMMIT && !store_re, "pixel write outside commit")
endmodule
`default_nettype wire

[test/tb_line_fragment_reassembly.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_line_fragment_reassembly;
	import lfr_pkg::*;

	localparam int unsigned NUM_PIXELS = 4096;
	localparam int unsigned CYCLE_LIMIT = 600000;
	// settle time after the last result before a register write or the end
	localparam int unsigned SETTLE_CYCLES = 24;

	typedef struct {
		opcode_t     op;
		logic [7:0]  ptype;
		logic [31:0] lid;
		logic [5:0]  fid;
		logic [6:0]  total;
		logic [12:0] fsize;
		logic [11:0] offset;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        eof;
	} pixel_item_t;

	typedef struct {
		status_t     status;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        line_ready;
		logic [31:0] ready_line;
	} line_result_t;

	// line store model: keeps its own copy of the reassembly state and the
	// registers, predicts one result per accepted transfer
	class line_store_model;
		logic        transform_on;
		logic [7:0]  header_type;
		logic [31:0] cur_line;
		logic [63:0] seen;
		int          frag_count;
		logic        fill;
		logic        line_ready;
		logic [31:0] ready_line;
		logic [23:0] pixels [2][NUM_PIXELS];
		bit          written [2][NUM_PIXELS];
		int          written_addrs [2][$];
		logic [16:0] gamma [256];
		line_result_t pending [$];
		int          errors;
		int          checked;
		int          status_hits [8];

		function new();
			transform_on = 1'b0;
			header_type  = '0;
			cur_line     = '0;
			seen         = '0;
			frag_count   = 0;
			fill         = 1'b0;
			line_ready   = 1'b0;
			ready_line   = '0;
			errors       = 0;
			checked      = 0;
			build_gamma();
		endfunction

		static function longint unsigned floor_sqrt(longint unsigned v);
			longint unsigned r;
			longint unsigned t;
			r = 0;
			for (int b = 31; b >= 0; b--) begin
				t = r | (64'd1 << b);
				if (t * t <= v) r = t;
			end
			return r;
		endfunction

		// log2 in 16 fraction bits by repeated squaring of the mantissa
		static function longint unsigned log2_fix(int unsigned v);
			int unsigned msb;
			longint unsigned m;
			longint unsigned frac;
			msb  = 0;
			frac = 0;
			while ((v >> (msb + 1)) != 0) msb++;
			m = longint'(v) << (30 - msb);
			for (int k = 1; k <= 16; k++) begin
				m = (m * m) >> 30;
				if (m >= (64'd1 << 31)) begin
					m    = m >> 1;
					frac = frac | (64'd1 << (16 - k));
				end
			end
			return (longint'(msb) << 16) + frac;
		endfunction

		function void build_gamma();
			longint unsigned half_roots [17];
			longint unsigned acc;
			longint unsigned full_log;
			longint unsigned expo;
			longint unsigned whole;
			longint unsigned scaled;
			acc = 64'd1 << 29;
			for (int k = 1; k <= 16; k++) begin
				acc = floor_sqrt(acc << 30);
				half_roots[k] = acc;
			end
			full_log = log2_fix(255);
			gamma[0] = '0;
			for (int i = 1; i < 256; i++) begin
				expo  = ((full_log - log2_fix(i)) * GAMMA_MILLI + 500) / 1000;
				whole = expo >> 16;
				acc   = 64'd1 << 30;
				for (int k = 1; k <= 16; k++)
					if (expo[16 - k]) acc = (acc * half_roots[k] + (64'd1 << 29)) >> 30;
				acc    = (whole >= 31) ? 64'd0 : (acc >> whole);
				scaled = (acc + 8192) >> 14;
				gamma[i] = (scaled > 65536) ? 17'd65536 : scaled[16:0];
			end
		endfunction

		function logic [7:0] scale_channel(logic [7:0] c, logic [16:0] f);
			longint unsigned p;
			p = (longint'(c) * f + 32768) >> 16;
			return p[7:0];
		endfunction

		function void config_write(logic idx, logic [7:0] data);
			if (idx == CFG_ENABLE_TRANSFORM) transform_on = data[0];
			else header_type = data;
		endfunction

		// a read is only ever aimed at a pixel of the ready bank that was written
		function bit pick_read_addr(output logic [11:0] addr);
			int q;
			q = written_addrs[~fill].size();
			addr = '0;
			if (q == 0) return 0;
			addr = 12'(written_addrs[~fill][$urandom_range(0, q - 1)]);
			return 1;
		endfunction

		// predict the result of one accepted input transfer
		function void note_input(pixel_item_t it);
			line_result_t res;
			int unsigned addr;
			int unsigned luma;
			logic [16:0] f;
			logic [7:0] r, g, b;
			res = '{STAT_WRONG, 8'd0, 8'd0, 8'd0, 1'b0, 32'd0};
			case (it.op)
				OP_PIXEL: begin
					if (it.ptype == header_type) begin
						if (it.lid != cur_line) begin
							cur_line   = it.lid;
							seen       = '0;
							frag_count = 0;
						end
						if (seen[it.fid]) begin
							res.status = STAT_DUPLICATE;
						end else begin
							addr = it.fid * it.fsize + it.offset;
							if (addr < NUM_PIXELS) begin
								r = it.red;
								g = it.green;
								b = it.blue;
								if (transform_on) begin
									luma = 299 * r + 587 * g + 114 * b;
									f = gamma[(255500 - luma) / 1000];
									r = scale_channel(r, f);
									g = scale_channel(g, f);
									b = scale_channel(b, f);
								end
								pixels[fill][addr] = {r, g, b};
								if (!written[fill][addr]) begin
									written[fill][addr] = 1;
									written_addrs[fill].push_back(addr);
								end
								res.status = STAT_WRITTEN;
							end else begin
								res.status = STAT_RANGE;
							end
							if (it.eof) begin
								seen[it.fid] = 1'b1;
								frag_count++;
								if (frag_count == it.total) begin
									fill       = ~fill;
									line_ready = 1'b1;
									ready_line = cur_line;
									res.status = STAT_COMPLETE;
								end
							end
						end
					end
				end
				OP_READ: begin
					{res.red, res.green, res.blue} = pixels[~fill][it.offset];
					res.status = STAT_READ;
				end
				OP_ACK: begin
					line_ready = 1'b0;
					res.status = STAT_ACKED;
				end
				default: res.status = STAT_WRONG;
			endcase
			res.line_ready = line_ready;
			res.ready_line = ready_line;
			pending.push_back(res);
		endfunction

		task report(string what);
			errors++;
			$display("mismatch at %0t: %s", $realtime, what);
		endtask

		task check_result(line_result_t got);
			line_result_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result, status %0d", got.status));
			end else begin
				want = pending.pop_front();
				checked++;
				status_hits[want.status]++;
				if (got.status !== want.status)
					report($sformatf("status %0d, want %0d", got.status, want.status));
				if ({got.red, got.green, got.blue} !== {want.red, want.green, want.blue})
					report($sformatf("color %h%h%h, want %h%h%h", got.red, got.green,
						got.blue, want.red, want.green, want.blue));
				if (got.line_ready !== want.line_ready)
					report($sformatf("line_ready %b, want %b", got.line_ready,
						want.line_ready));
				if (got.ready_line !== want.ready_line)
					report($sformatf("ready_line_number %h, want %h", got.ready_line,
						want.ready_line));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	lfr_item_if   item ();
	lfr_result_if result ();
	lfr_cfg_if    cfg ();

	line_fragment_reassembly u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item.sink),
		.result (result.source),
		.cfg    (cfg.sink)
	);

	line_store_model store;

	// sender burst state and receiver stall pattern
	int          burst_left;
	int          max_gap;
	int          stall_mode;
	logic [15:0] stall_pattern;
	int unsigned cycle_count;
	int          items_sent;
	int          lines_started;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// timeout guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("simulation failed");
			$finish;
		end
	end

	// receiver: always ready, coin flip, or a rotating 16-bit pattern
	always @(posedge clk) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			case (stall_mode)
				0: result.ready <= 1'b1;
				1: result.ready <= 1'($urandom_range(0, 1));
				default: result.ready <= stall_pattern[cycle_count[3:0]];
			endcase
		end
	end

	// result monitor: sees pre-edge values since every driver uses nonblocking writes
	always @(posedge clk) begin
		line_result_t got;
		if (arst_n && result.valid && result.ready) begin
			got.status     = status_t'(result.status);
			got.red        = result.red_out;
			got.green      = result.green_out;
			got.blue       = result.blue_out;
			got.line_ready = result.line_ready;
			got.ready_line = result.ready_line_number;
			store.check_result(got);
		end
	end

	// drive one item, honoring the burst/gap pattern, until its transfer
	task send_item(pixel_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
			if (gap > 0) begin
				item.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item.valid           <= 1'b1;
		item.opcode          <= it.op;
		item.packet_type     <= it.ptype;
		item.line_id         <= it.lid;
		item.frag_index      <= it.fid;
		item.frag_total      <= it.total;
		item.frag_pixels     <= it.fsize;
		item.pixel_offset    <= it.offset;
		item.red_in          <= it.red;
		item.green_in        <= it.green;
		item.blue_in         <= it.blue;
		item.end_of_fragment <= it.eof;
		do @(posedge clk); while (!item.ready);
		store.note_input(it);
		if (it.op != OP_NONE && !(it.op == OP_PIXEL && it.ptype != store.header_type))
			items_sent++;
	endtask

	function pixel_item_t make_pixel(logic [31:0] lid, logic [5:0] fid, logic [6:0] total,
			logic [12:0] fsize, logic [11:0] offset, logic eof);
		pixel_item_t it;
		it.op     = OP_PIXEL;
		it.ptype  = store.header_type;
		it.lid    = lid;
		it.fid    = fid;
		it.total  = total;
		it.fsize  = fsize;
		it.offset = offset;
		it.red    = 8'($urandom_range(0, 255));
		it.green  = 8'($urandom_range(0, 255));
		it.blue   = 8'($urandom_range(0, 255));
		it.eof    = eof;
		return it;
	endfunction

	function pixel_item_t make_cmd(opcode_t op, logic [11:0] offset);
		pixel_item_t it;
		it        = make_pixel($urandom, 6'($urandom), 7'($urandom), 13'($urandom), offset,
			1'($urandom));
		it.op     = op;
		it.ptype  = 8'($urandom);
		return it;
	endfunction

	// read of a written ready-bank pixel, or an acknowledge when none exists
	task send_read();
		logic [11:0] addr;
		if (store.pick_read_addr(addr)) send_item(make_cmd(OP_READ, addr));
		else send_item(make_cmd(OP_ACK, '0));
	endtask

	// one noise item: read, acknowledge, wrong type, unused opcode, or stray pixel
	task send_noise(logic [31:0] lid);
		pixel_item_t it;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: send_read();
			4, 5: send_item(make_cmd(OP_ACK, 12'($urandom)));
			6: begin
				it = make_pixel($urandom, 6'($urandom), 7'($urandom), 13'($urandom),
					12'($urandom), 1'($urandom));
				it.ptype = store.header_type ^ 8'($urandom_range(1, 255));
				send_item(it);
			end
			7: send_item(make_cmd(OP_NONE, 12'($urandom)));
			default: begin
				// stray pixel of the current line, any field values
				it = make_pixel(lid, 6'($urandom), 7'($urandom), 13'($urandom),
					12'($urandom), 1'($urandom));
				send_item(it);
			end
		endcase
	endtask

	// one well-formed line: fragments in random order, occasional noise and repeats
	task send_line(logic [31:0] lid, int total, int fsize, bit sparse);
		int order [$];
		int pix;
		int j;
		lines_started++;
		for (int k = 0; k < total; k++) order.push_back(k);
		order.shuffle();
		foreach (order[k]) begin
			// sparse lines send one pixel per fragment at a random offset
			pix = sparse ? 1 : fsize;
			for (int p = 0; p < pix; p++) begin
				j = sparse ? $urandom_range(0, (fsize > 4096 ? 4096 : fsize) - 1) : p;
				send_item(make_pixel(lid, 6'(order[k]), 7'(total), 13'(fsize), 12'(j),
					p == pix - 1));
				if ($urandom_range(0, 7) == 0) send_noise(lid);
				// repeat of an already finished fragment
				if ($urandom_range(0, 15) == 0 && k > 0)
					send_item(make_pixel(lid, 6'(order[$urandom_range(0, k - 1)]), 7'(total),
						13'(fsize), 12'd0, 1'($urandom)));
			end
		end
		// a trailing pixel after completion and a consumer pass over the line
		if ($urandom_range(0, 3) == 0)
			send_item(make_pixel(lid, 6'(order[0]), 7'(total), 13'(fsize), 12'd0, 1'b1));
		repeat ($urandom_range(0, 3)) send_read();
		if ($urandom_range(0, 1) == 0) send_item(make_cmd(OP_ACK, '0));
	endtask

	task write_register(logic idx, logic [7:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		do @(posedge clk); while (!cfg.ready);
		store.config_write(idx, data);
		cfg.valid <= 1'b0;
	endtask

	// wait out all expected results plus the block's internal latency
	task drain();
		item.valid <= 1'b0;
		while (store.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task directed_items();
		pixel_item_t it;
		// wrong packet type, unused opcode, acknowledge with nothing ready
		it = make_pixel(32'h0, 6'd0, 7'd1, 13'd1, 12'd0, 1'b1);
		it.ptype = ~store.header_type;
		send_item(it);
		send_item(make_cmd(OP_NONE, 12'hFFF));
		send_item(make_cmd(OP_ACK, '0));
		// extreme line id and size: last in-range pixel, then an out-of-range
		// address that still completes the line
		it = make_pixel(32'hFFFF_FFFF, 6'd0, 7'd2, 13'd4096, 12'hFFF, 1'b1);
		{it.red, it.green, it.blue} = 24'hFFFFFF;
		send_item(it);
		it = make_pixel(32'hFFFF_FFFF, 6'd1, 7'd2, 13'd4096, 12'd0, 1'b1);
		{it.red, it.green, it.blue} = 24'h000000;
		send_item(it);
		// duplicate after completion, read back the last in-range pixel, acknowledge
		send_item(make_pixel(32'hFFFF_FFFF, 6'd0, 7'd2, 13'd4096, 12'd5, 1'b1));
		send_item(make_cmd(OP_READ, 12'hFFF));
		send_item(make_cmd(OP_ACK, '0));
		// widest fragment size field, pixel before the end of fragment
		send_item(make_pixel(32'h0, 6'd0, 7'd1, 13'h1FFF, 12'd0, 1'b0));
		send_item(make_pixel(32'h0, 6'd0, 7'd1, 13'h1FFF, 12'd1, 1'b1));
		send_item(make_cmd(OP_READ, 12'd1));
		// unreachable totals: zero and above the fragment limit
		send_item(make_pixel(32'h5, 6'd3, 7'd0, 13'd1, 12'd0, 1'b1));
		send_item(make_pixel(32'h5, 6'd4, 7'd100, 13'd1, 12'd0, 1'b1));
		send_item(make_pixel(32'h5, 6'd4, 7'd100, 13'd1, 12'd0, 1'b1));
		// highest fragment id and top total field value
		send_item(make_pixel(32'h7, 6'd63, 7'd127, 13'd1, 12'd0, 1'b1));
		send_item(make_pixel(32'h7, 6'd63, 7'd64, 13'd64, 12'd63, 1'b1));
		// a full 64-fragment line, one pixel each
		send_line(32'hA5A5_0001, 64, 1, 1'b0);
	endtask

	task random_phase(int quota);
		int stop_at;
		int kind;
		logic [31:0] lid;
		stop_at = items_sent + quota;
		while (items_sent < stop_at) begin
			kind = $urandom_range(0, 19);
			lid = ($urandom_range(0, 15) == 0) ? {32{$urandom_range(0, 1) == 1}} : $urandom;
			if (kind < 14)
				send_line(lid, $urandom_range(1, 4), $urandom_range(1, 6), 1'b0);
			else if (kind < 16)
				send_line(lid, $urandom_range(1, 3), $urandom_range(1000, 4096), 1'b1);
			else if (kind == 16)
				send_line(lid, $urandom_range(5, 64), $urandom_range(1, 64), 1'b1);
			else if (kind == 17)
				// same id again: fragments already seen report duplicate
				send_line(store.cur_line, $urandom_range(1, 3), $urandom_range(1, 4), 1'b0);
			else
				repeat ($urandom_range(1, 6)) send_noise(store.cur_line);
		end
	endtask

	initial begin
		logic [7:0] headers [5];
		logic       transforms [5];
		store         = new();
		arst_n        = 1'b0;
		cycle_count   = 0;
		items_sent    = 0;
		lines_started = 0;
		burst_left    = 0;
		max_gap       = 0;
		stall_mode    = 0;
		stall_pattern = 16'hFFFF;
		item.valid           = 1'b0;
		item.opcode          = OP_NONE;
		item.packet_type     = '0;
		item.line_id         = '0;
		item.frag_index      = '0;
		item.frag_total      = '0;
		item.frag_pixels     = '0;
		item.pixel_offset    = '0;
		item.red_in          = '0;
		item.green_in        = '0;
		item.blue_in         = '0;
		item.end_of_fragment = 1'b0;
		cfg.valid            = 1'b0;
		cfg.index            = CFG_ENABLE_TRANSFORM;
		cfg.data             = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register settings per phase, extremes first
		transforms = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
		headers    = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'($urandom)};
		for (int ph = 0; ph < 5; ph++) begin
			write_register(CFG_ENABLE_TRANSFORM, 8'(transforms[ph]));
			write_register(CFG_HEADER_TYPE, headers[ph]);
			// phase 0 runs without idling, the others add sender gaps, and all but phase 3 receiver stalls
			max_gap       = (ph == 0) ? 0 : (ph % 2 == 0 ? 8 : 3);
			stall_mode    = ph % 3;
			stall_pattern = 16'($urandom) | 16'h0101;
			if (ph == 0) directed_items();
			random_phase(350);
			drain();
		end

		if (store.pending.size() != 0)
			store.report($sformatf("%0d results never arrived", store.pending.size()));
		$display("covered %0d lines and %0d counted items over 5 register settings, %0d results checked",
			lines_started, items_sent, store.checked);
		$display("results: written %0d dup %0d complete %0d wrong %0d range %0d read %0d ack %0d",
			store.status_hits[STAT_WRITTEN], store.status_hits[STAT_DUPLICATE],
			store.status_hits[STAT_COMPLETE], store.status_hits[STAT_WRONG],
			store.status_hits[STAT_RANGE], store.status_hits[STAT_READ],
			store.status_hits[STAT_ACKED]);
		if (store.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
`default_nettype wire

[filelist.f]
+incdir+rtl/core
rtl/core/lfr_pkg.sv
rtl/core/lfr_ifs.sv
rtl/core/lfr_xform.sv
rtl/core/lfr_store.sv
rtl/core/line_fragment_reassembly.sv
test/tb_line_fragment_reassembly.sv
